### design/ceu_pkg.sv
package ceu_pkg;

    // Longest burst of output bytes that one input byte can cause.
    localparam int CmdBytes = 5;
    localparam int CntW     = $clog2(CmdBytes + 1);
    localparam int IdxW     = $clog2(CmdBytes);

    // Depth of the queue between parser and serializer.
    localparam int QDepth   = 4;
    localparam int QPtrW    = $clog2(QDepth);
    localparam int QCntW    = $clog2(QDepth + 1);

    // Characters the parser looks for.
    localparam logic [7:0] ChAmp   = 8'h26;
    localparam logic [7:0] ChHash  = 8'h23;
    localparam logic [7:0] ChSemi  = 8'h3B;
    localparam logic [7:0] ChXLow  = 8'h78;
    localparam logic [7:0] ChXUp   = 8'h58;

    // One burst of output bytes, in order, with its length.
    typedef struct packed {
        logic [CmdBytes-1:0][7:0] bytes;
        logic [CntW-1:0]          count;
    } t_cmd;

    // Queue status seen by the parser and the serializer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

### design/char_entity_to_utf8.sv
// Channel   Dir  tdata             tlast                 tuser
// s (in)    in   [7:0] text byte   final byte of stream  -
// m (out)   out  [7:0] output byte last byte of a burst  -
//
// Each input byte is parsed in the cycle it is accepted; one input byte is taken per cycle unless the queue is full.
// An input byte releases zero to five output bytes, sent one per cycle while the receiver is
// ready, so the output rate of one byte per cycle sets the sustained figure.
// A four-entry queue of bursts sits between parser and serializer; input stalls only
// when it is full. Reset is synchronous, active low, and empties the queue.
module char_entity_to_utf8
    import ceu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] out_byte
    output logic       o_m_tlast
);

    t_qstat qstat;
    t_cmd   cmd;
    t_cmd   head;
    logic   push;
    logic   pop;

    ceu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    ceu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (head)
    );

    ceu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (qstat),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_m_tready (i_m_tready)
    );

    // A burst is never written into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("burst written into full queue");

    // Every queued burst holds between one and five bytes.
    a_burst_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (cmd.count != '0) && (cmd.count <= CntW'(CmdBytes)))
        else $error("burst length out of range");

    // The head entry is only released on its final byte.
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> o_m_tvalid && o_m_tlast && i_m_tready)
        else $error("queue entry released early");

endmodule

### design/ceu_front.sv
module ceu_front
    import ceu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    output logic       o_s_tready,
    input  t_qstat     i_qstat,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_AMP,
        PH_HASH,
        PH_XLO,
        PH_XUP,
        PH_DEC,
        PH_HEX
    } t_phase;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_utf8;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    localparam logic [31:0] Lim1 = 32'h0000_007F;
    localparam logic [31:0] Lim2 = 32'h0000_07FF;
    localparam logic [31:0] Lim3 = 32'h0000_FFFF;
    localparam logic [31:0] Lim4 = 32'h001F_FFFF;

    // UTF-8 encoding of a code point; values past the four-byte range give nothing.
    function automatic t_utf8 utf8_enc(input logic [31:0] cp);
        t_utf8 u;
        u = '0;
        if (cp <= Lim1) begin
            u.b[0] = cp[7:0];
            u.n    = 3'd1;
        end else if (cp <= Lim2) begin
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
            u.n    = 3'd2;
        end else if (cp <= Lim3) begin
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
            u.n    = 3'd3;
        end else if (cp <= Lim4) begin
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
            u.n    = 3'd4;
        end
        return u;
    endfunction

    function automatic t_hex hex_dec(input logic [7:0] c);
        t_hex h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h57);
        end
        return h;
    endfunction

    t_phase                   r_phase, n_phase;
    logic [31:0]              r_acc, n_acc;
    logic                     accept;
    logic                     is_dig;
    t_hex                     hx;
    logic [1:0]               pre_n;
    logic [7:0]               pre_x;
    logic                     term;
    logic                     as_text;
    logic                     text_put;
    t_phase                   mid_phase;
    logic [31:0]              mid_acc;
    t_utf8                    u;
    logic [CmdBytes-1:0][7:0] obuf;
    logic [CntW-1:0]          oc;

    assign o_s_tready = !i_qstat.full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_dig     = (i_s_tdata >= 8'h30) && (i_s_tdata <= 8'h39);
    assign hx         = hex_dec(i_s_tdata);

    // Parser step: next phase and accumulator, plus what this byte releases.
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        pre_n    = 2'd0;
        pre_x    = ChXLow;
        term     = 1'b0;
        as_text  = 1'b0;
        text_put = 1'b0;
        case (r_phase)
            PH_AMP: begin
                if (i_s_tdata == ChHash) begin
                    n_phase = PH_HASH;
                end else begin
                    pre_n   = 2'd1;
                    as_text = 1'b1;
                end
            end
            PH_HASH: begin
                if (i_s_tdata == ChXLow) begin
                    n_phase = PH_XLO;
                end else if (i_s_tdata == ChXUp) begin
                    n_phase = PH_XUP;
                end else if (is_dig) begin
                    n_acc   = {28'd0, hx.val};
                    n_phase = PH_DEC;
                end else begin
                    pre_n   = 2'd2;
                    as_text = 1'b1;
                end
            end
            PH_XLO, PH_XUP: begin
                if (hx.ok) begin
                    n_acc   = {28'd0, hx.val};
                    n_phase = PH_HEX;
                end else begin
                    pre_n   = 2'd3;
                    pre_x   = (r_phase == PH_XLO) ? ChXLow : ChXUp;
                    as_text = 1'b1;
                end
            end
            PH_DEC: begin
                if (is_dig) begin
                    n_acc = (r_acc << 3) + (r_acc << 1) + {28'd0, hx.val};
                end else begin
                    term    = 1'b1;
                    n_acc   = '0;
                    n_phase = PH_TEXT;
                    as_text = (i_s_tdata != ChSemi);
                end
            end
            PH_HEX: begin
                if (hx.ok) begin
                    n_acc = {r_acc[27:0], hx.val};
                end else begin
                    term    = 1'b1;
                    n_acc   = '0;
                    n_phase = PH_TEXT;
                    as_text = (i_s_tdata != ChSemi);
                end
            end
            default: begin
                as_text = 1'b1;
            end
        endcase
        if (as_text) begin
            n_acc = '0;
            if (i_s_tdata == ChAmp) begin
                n_phase = PH_AMP;
            end else begin
                n_phase  = PH_TEXT;
                text_put = 1'b1;
            end
        end
        mid_phase = n_phase;
        mid_acc   = n_acc;
        if (i_s_tlast) begin
            n_phase = PH_TEXT;
            n_acc   = '0;
        end
    end

    // A terminated reference encodes the old value; a flush encodes the updated one.
    assign u = utf8_enc(term ? r_acc : mid_acc);

    // Lay out the output bytes in the order they leave the block.
    always_comb begin
        obuf = '0;
        oc   = '0;
        if (pre_n != 2'd0) begin
            obuf[IdxW'(oc)] = ChAmp;
            oc = oc + 1'b1;
        end
        if (pre_n >= 2'd2) begin
            obuf[IdxW'(oc)] = ChHash;
            oc = oc + 1'b1;
        end
        if (pre_n == 2'd3) begin
            obuf[IdxW'(oc)] = pre_x;
            oc = oc + 1'b1;
        end
        if (term) begin
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < u.n) begin
                    obuf[IdxW'(oc)] = u.b[k];
                    oc = oc + 1'b1;
                end
            end
        end
        if (text_put) begin
            obuf[IdxW'(oc)] = i_s_tdata;
            oc = oc + 1'b1;
        end
        if (i_s_tlast) begin
            case (mid_phase)
                PH_AMP: begin
                    obuf[IdxW'(oc)] = ChAmp;
                    oc = oc + 1'b1;
                end
                PH_HASH, PH_XLO, PH_XUP: begin
                    obuf[IdxW'(oc)] = ChAmp;
                    oc = oc + 1'b1;
                    obuf[IdxW'(oc)] = ChHash;
                    oc = oc + 1'b1;
                    if (mid_phase != PH_HASH) begin
                        obuf[IdxW'(oc)] = (mid_phase == PH_XLO) ? ChXLow : ChXUp;
                        oc = oc + 1'b1;
                    end
                end
                PH_DEC, PH_HEX: begin
                    for (int k = 0; k < 4; k++) begin
                        if (3'(k) < u.n) begin
                            obuf[IdxW'(oc)] = u.b[k];
                            oc = oc + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_push      = accept && (oc != '0);
    assign o_cmd.bytes = obuf;
    assign o_cmd.count = oc;

    // Parser state advances on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_acc   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

endmodule

### design/ceu_queue.sv
module ceu_queue
    import ceu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_qstat o_qstat,
    output t_cmd   o_head
);

    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;

    assign o_qstat.full  = (r_count == QCntW'(QDepth));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/ceu_back.sv
module ceu_back
    import ceu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qstat     i_qstat,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_m_tvalid,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast,
    input  logic       i_m_tready
);

    logic [IdxW-1:0] r_idx;
    logic            take;

    assign o_m_tvalid = !i_qstat.empty;
    assign o_m_tdata  = i_head.bytes[r_idx];
    assign o_m_tlast  = (CntW'(r_idx) + 1'b1 == i_head.count);
    assign take       = o_m_tvalid && i_m_tready;
    assign o_pop      = take && o_m_tlast;

    // Walk through the bytes of the head entry, one per transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            if (o_m_tlast) begin
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

### dv/tb_char_entity_to_utf8.sv
module tb_char_entity_to_utf8;
    import ceu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RandItems   = 500;
    localparam int  HoldCycles  = 80;
    localparam int  HoldAfterIn = 150;
    localparam int  DrainLimit  = 5000;
    localparam int  SettleCyc   = 20;
    localparam real TimeoutNs   = 10_000_000.0;

    // UTF-8 length boundaries.
    localparam logic [31:0] Lim1Byte = 32'h7F;
    localparam logic [31:0] Lim2Byte = 32'h7FF;
    localparam logic [31:0] Lim3Byte = 32'hFFFF;
    localparam logic [31:0] Lim4Byte = 32'h1FFFFF;

    typedef enum logic [2:0] {
        ST_TEXT, ST_AMP, ST_HASH, ST_XLOW, ST_XUP, ST_DEC, ST_HEX
    } dec_phase_t;

    // One input byte, with an optional hand-written expectation.
    typedef struct packed {
        logic [7:0]      data;
        logic            last;
        logic            typed;
        logic [2:0]      n;
        logic [0:3][7:0] want;
    } text_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    // Directed table: extremes, each malformed form, the longest burst, end-of-stream flush.
    localparam int DirRows = 26;
    localparam text_item_t DirTable [DirRows] = '{
        '{"A",     1'b0, 1'b1, 3'd1, {"A", 8'h00, 8'h00, 8'h00}},
        '{8'h00,   1'b0, 1'b1, 3'd1, {8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'hFF,   1'b1, 1'b1, 3'd1, {8'hFF, 8'h00, 8'h00, 8'h00}},
        '{ChAmp,   1'b0, 1'b1, 3'd0, 32'h0},
        '{"B",     1'b0, 1'b1, 3'd2, {ChAmp, "B", 8'h00, 8'h00}},
        '{ChAmp,   1'b0, 1'b1, 3'd0, 32'h0},
        '{ChHash,  1'b0, 1'b1, 3'd0, 32'h0},
        '{"z",     1'b0, 1'b1, 3'd3, {ChAmp, ChHash, "z", 8'h00}},
        '{ChAmp,   1'b0, 1'b1, 3'd0, 32'h0},
        '{ChHash,  1'b0, 1'b1, 3'd0, 32'h0},
        '{ChXLow,  1'b0, 1'b1, 3'd0, 32'h0},
        '{ChSemi,  1'b0, 1'b1, 3'd4, {ChAmp, ChHash, ChXLow, ChSemi}},
        '{ChAmp,   1'b0, 1'b0, 3'd0, 32'h0},
        '{ChHash,  1'b0, 1'b0, 3'd0, 32'h0},
        '{ChXUp,   1'b0, 1'b0, 3'd0, 32'h0},
        '{"1",     1'b0, 1'b0, 3'd0, 32'h0},
        '{"0",     1'b0, 1'b0, 3'd0, 32'h0},
        '{"F",     1'b0, 1'b0, 3'd0, 32'h0},
        '{"f",     1'b0, 1'b0, 3'd0, 32'h0},
        '{"F",     1'b0, 1'b0, 3'd0, 32'h0},
        '{"F",     1'b0, 1'b0, 3'd0, 32'h0},
        '{"<",     1'b0, 1'b0, 3'd0, 32'h0},
        '{ChAmp,   1'b0, 1'b0, 3'd0, 32'h0},
        '{ChHash,  1'b0, 1'b0, 3'd0, 32'h0},
        '{"9",     1'b1, 1'b1, 3'd1, {8'h09, 8'h00, 8'h00, 8'h00}},
        '{ChAmp,   1'b1, 1'b1, 3'd1, {ChAmp, 8'h00, 8'h00, 8'h00}}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;    // [7:0] in_byte
    logic       i_s_tlast;
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;    // [7:0] out_byte
    logic       o_m_tlast;

    char_entity_to_utf8 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    text_item_t text_items [$];
    out_beat_t  pending_bytes [$];
    logic [7:0] burst [$];

    dec_phase_t  dec_phase = ST_TEXT;
    logic [31:0] dec_acc   = '0;

    int n_err      = 0;
    int n_in_acc   = 0;
    int n_out_acc  = 0;
    int n_refs     = 0;
    int n_dropped  = 0;
    int n_stalls   = 0;
    int tx_calm    = 0;
    int rx_calm    = 0;
    bit hold_done  = 0;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Decoder prediction.
    function automatic void put_byte(input logic [7:0] b);
        if (burst.size() < CmdBytes) burst.push_back(b);
    endfunction

    function automatic void put_code_point(input logic [31:0] cp);
        n_refs++;
        if (cp <= Lim1Byte) begin
            put_byte(cp[7:0]);
        end else if (cp <= Lim2Byte) begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end else if (cp <= Lim3Byte) begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end else if (cp <= Lim4Byte) begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end else begin
            n_dropped++;
        end
    endfunction

    function automatic bit dec_char(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic int hex_value(input logic [7:0] b);
        if (dec_char(b)) return int'(b - "0");
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        return -1;
    endfunction

    // A byte seen as plain text; an ampersand opens a new reference.
    function automatic void text_byte(input logic [7:0] b);
        dec_phase = ST_TEXT;
        dec_acc   = '0;
        if (b == ChAmp) dec_phase = ST_AMP;
        else            put_byte(b);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int hv;
        burst.delete();
        case (dec_phase)
            ST_AMP: begin
                if (b == ChHash) begin
                    dec_phase = ST_HASH;
                end else begin
                    put_byte(ChAmp);
                    text_byte(b);
                end
            end
            ST_HASH: begin
                if (b == ChXLow) begin
                    dec_phase = ST_XLOW;
                end else if (b == ChXUp) begin
                    dec_phase = ST_XUP;
                end else if (dec_char(b)) begin
                    dec_acc   = 32'(b - "0");
                    dec_phase = ST_DEC;
                end else begin
                    put_byte(ChAmp);
                    put_byte(ChHash);
                    text_byte(b);
                end
            end
            ST_XLOW, ST_XUP: begin
                hv = hex_value(b);
                if (hv >= 0) begin
                    dec_acc   = 32'(hv);
                    dec_phase = ST_HEX;
                end else begin
                    put_byte(ChAmp);
                    put_byte(ChHash);
                    put_byte((dec_phase == ST_XLOW) ? ChXLow : ChXUp);
                    text_byte(b);
                end
            end
            ST_DEC: begin
                if (dec_char(b)) begin
                    dec_acc = dec_acc * 32'd10 + 32'(b - "0");
                end else begin
                    put_code_point(dec_acc);
                    dec_acc   = '0;
                    dec_phase = ST_TEXT;
                    if (b != ChSemi) text_byte(b);
                end
            end
            ST_HEX: begin
                hv = hex_value(b);
                if (hv >= 0) begin
                    dec_acc = {dec_acc[27:0], 4'h0} + 32'(hv);
                end else begin
                    put_code_point(dec_acc);
                    dec_acc   = '0;
                    dec_phase = ST_TEXT;
                    if (b != ChSemi) text_byte(b);
                end
            end
            default: text_byte(b);
        endcase

        // End of stream flushes whatever is still pending.
        if (last) begin
            case (dec_phase)
                ST_AMP: put_byte(ChAmp);
                ST_HASH: begin
                    put_byte(ChAmp);
                    put_byte(ChHash);
                end
                ST_XLOW, ST_XUP: begin
                    put_byte(ChAmp);
                    put_byte(ChHash);
                    put_byte((dec_phase == ST_XLOW) ? ChXLow : ChXUp);
                end
                ST_DEC, ST_HEX: put_code_point(dec_acc);
                default: ;
            endcase
            dec_phase = ST_TEXT;
            dec_acc   = '0;
        end
    endfunction

    // Stimulus building.
    function automatic void add_byte(input logic [7:0] b);
        text_item_t it;
        it       = '0;
        it.data  = b;
        it.last  = ($urandom_range(0, 39) == 0);
        text_items.push_back(it);
    endfunction

    // Half of the sequences are references with random digits, the rest noise and broken forms.
    task automatic add_random_sequence();
        int kind, nd, v, term;
        bit hex;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            add_byte(8'($urandom_range(0, 255)));
        end else if (kind < 80) begin
            hex = (kind >= 55);
            add_byte(ChAmp);
            add_byte(ChHash);
            if (hex) add_byte($urandom_range(0, 1) ? ChXLow : ChXUp);
            nd = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int k = 0; k < nd; k++) begin
                v = hex ? $urandom_range(0, 15) : $urandom_range(0, 9);
                if (v < 10) add_byte(8'("0" + v));
                else        add_byte(8'(($urandom_range(0, 1) ? "a" : "A") + v - 10));
            end
            term = $urandom_range(0, 99);
            if (term < 50)      add_byte(ChSemi);
            else if (term < 80) add_byte(8'($urandom_range(0, 255)));
        end else if (kind < 92) begin
            v = $urandom_range(0, 2);
            add_byte(ChAmp);
            if (v >= 1) add_byte(ChHash);
            if (v == 2) add_byte($urandom_range(0, 1) ? ChXLow : ChXUp);
            add_byte(8'($urandom_range(0, 255)));
        end else begin
            add_byte(8'($urandom_range(32, 126)));
        end
    endtask

    // Idle length: mostly none, some short, a few long, with idle-free stretches.
    function automatic int pick_gap(ref int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Monitor: check output transactions, then predict from input transactions.
    always @(posedge i_clk) begin
        out_beat_t  want;
        text_item_t it;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                n_out_acc++;
                if (pending_bytes.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected output byte %h last %b", $time,
                             o_m_tdata, o_m_tlast);
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_m_tdata !== want.data) begin
                        n_err++;
                        $display("%0t: out_byte expected %h actual %h", $time,
                                 want.data, o_m_tdata);
                    end
                    if (o_m_tlast !== want.last) begin
                        n_err++;
                        $display("%0t: run_last expected %b actual %b", $time,
                                 want.last, o_m_tlast);
                    end
                end
            end
            if (i_s_tvalid && !o_s_tready) n_stalls++;
            if (i_s_tvalid && o_s_tready && n_in_acc < text_items.size()) begin
                it = text_items[n_in_acc];
                n_in_acc++;
                decode_byte(it.data, it.last);
                if (it.typed) begin
                    burst.delete();
                    for (int k = 0; k < it.n; k++) burst.push_back(it.want[k]);
                end
                for (int k = 0; k < burst.size(); k++) begin
                    want.data = burst[k];
                    want.last = (k == burst.size() - 1);
                    pending_bytes.push_back(want);
                end
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off while input keeps coming.
    initial begin
        int gap;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_in_acc >= HoldAfterIn) begin
                hold_done  = 1;
                i_m_tready = 1'b0;
                repeat (HoldCycles - 1) @(negedge i_clk);
            end else begin
                gap = pick_gap(rx_calm);
                if (gap == 0) begin
                    i_m_tready = 1'b1;
                end else begin
                    i_m_tready = 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Run limit.
    initial begin
        #(TimeoutNs);
        $display("%0t: run limit reached, %0d bytes still expected", $time,
                 pending_bytes.size());
        $display("** char_entity_to_utf8: FAILED **");
        $finish;
    end

    // Reset, stimulus, drain and verdict.
    initial begin
        int gap, waited;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;

        foreach (DirTable[i]) text_items.push_back(DirTable[i]);
        while (text_items.size() < DirRows + RandItems) add_random_sequence();
        text_items[text_items.size() - 1].last = 1'b1;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Sender: one input transaction per item, idle gaps in between.
        for (int idx = 0; idx < text_items.size(); idx++) begin
            gap = pick_gap(tx_calm);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_s_tvalid = 1'b1;
            i_s_tdata  = text_items[idx].data;
            i_s_tlast  = text_items[idx].last;
            do @(posedge i_clk); while (!o_s_tready);
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b0;

        waited = 0;
        while (pending_bytes.size() > 0 && waited < DrainLimit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SettleCyc) @(posedge i_clk);
        if (pending_bytes.size() > 0) begin
            n_err++;
            $display("%0t: %0d expected bytes never arrived, next %h", $time,
                     pending_bytes.size(), pending_bytes[0].data);
        end

        $display("Sent %0d text bytes (%0d directed), received %0d output bytes.",
                 n_in_acc, DirRows, n_out_acc);
        $display("Decoded %0d references (%0d out of range), input stalled %0d cycles.",
                 n_refs, n_dropped, n_stalls);
        if (n_err == 0) begin
            $display("** char_entity_to_utf8: PASSED **");
        end else begin
            $display("** char_entity_to_utf8: FAILED **");
        end
        $finish;
    end

endmodule
